// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker, included by stkc_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/stkc_pkg.sv =====
// Types and constants for the sorted table key counter
package stkc_pkg;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam int KEY_W   = 32;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;
   localparam int CMP_W   = 64;

   typedef struct packed {
      logic                      req_type;
      logic [INDEX_W-1:0]        index;
      logic signed [KEY_W-1:0]   value;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] match_count;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EQ
   } fsm_state_type;

endpackage

// ===== hdl/stkc_ifs.sv =====
// Valid/ready channel interfaces for requests and responses
interface stkc_req_if import stkc_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface stkc_rsp_if import stkc_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/sorted_table_key_count_top.sv =====
// Write: stored when the request is taken (index below TABLE_DEPTH), no response. Query: lower-bound
// then upper-bound binary search, at most one table read per cycle, then an equality check at the
// lower bound; the response waits for a free output slot, and the next request is taken only after
// the response is issued, so one query is in flight at a time; the single read port sets the pace.
// Reset clears control state and sets entry_count to 1; table contents stay undefined
// until written and are never cleared.
module sorted_table_key_count_top import stkc_pkg::*; #(
   parameter int TABLE_DEPTH = 1024,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   stkc_req_if.sink           req_if,
   stkc_rsp_if.source         rsp_if
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic signed [ENTRY_WIDTH-1:0] mem_ff [TABLE_DEPTH];
   logic signed [ENTRY_WIDTH-1:0] rd_data_ff;

   fsm_state_type        state_ff, state_in;
   logic [COUNT_W-1:0]   entry_count_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 pend_ff, pend_in;
   logic                 phase_ff, phase_in;    // 0: lower bound, 1: upper bound
   logic [CW-1:0]        lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CW-1:0]        lb_ff, lb_in, ub_ff, ub_in, n_ff, n_in;
   logic signed [KEY_W-1:0] key_ff, key_in;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic signed [CMP_W-1:0] wr_ext;

   logic [CW-1:0]        lo_c, hi_c, mid_c;
   logic signed [CMP_W-1:0] entry_ext, key_ext;
   logic                 go_right, hit;
   logic [31:0]          idx32, n32, diff32;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data.match_count = rsp_count_ff;

   // table write path
   always_comb begin
      idx32   = 32'(req_if.data.index);
      wr_ext  = CMP_W'(req_if.data.value);
      wr_en   = req_if.valid && req_if.ready && (req_if.data.req_type == REQ_WRITE)
                && (idx32 < 32'(TABLE_DEPTH));
      wr_addr = idx32[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_ext[ENTRY_WIDTH-1:0];
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      pend_in      = pend_ff;
      phase_in     = phase_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      lb_in        = lb_ff;
      ub_in        = ub_ff;
      n_in         = n_ff;
      key_in       = key_ff;
      rd_en        = 1'b0;
      rd_addr      = lb_ff[AW-1:0];
      lo_c         = lo_ff;
      hi_c         = hi_ff;
      mid_c        = mid_ff;
      entry_ext    = CMP_W'(rd_data_ff);
      key_ext      = CMP_W'(key_ff);
      go_right     = phase_ff ? (entry_ext <= key_ext) : (entry_ext < key_ext);
      n32          = (32'(entry_count_ff) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                               : 32'(entry_count_ff);
      diff32       = 32'(ub_ff - lb_ff);
      hit          = (ub_ff > lb_ff) && (lb_ff < n_ff) && (entry_ext == key_ext);

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid && req_if.data.req_type == REQ_QUERY) begin
               key_in   = req_if.data.value;
               n_in     = n32[CW-1:0];
               lo_in    = '0;
               hi_in    = n32[CW-1:0];
               phase_in = 1'b0;
               pend_in  = 1'b0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // fold in the outstanding probe, then issue the next one
            if (pend_ff) begin
               if (go_right) begin
                  lo_c = mid_ff + CW'(1);
               end else begin
                  hi_c = mid_ff;
               end
            end
            if (lo_c < hi_c) begin
               mid_c   = lo_c + ((hi_c - lo_c) >> 1);
               rd_en   = 1'b1;
               rd_addr = mid_c[AW-1:0];
               mid_in  = mid_c;
               pend_in = 1'b1;
               lo_in   = lo_c;
               hi_in   = hi_c;
            end else begin
               pend_in = 1'b0;
               if (!phase_ff) begin
                  lb_in    = lo_c;
                  lo_in    = '0;
                  hi_in    = n_ff;
                  phase_in = 1'b1;
               end else begin
                  ub_in    = lo_c;
                  rd_en    = 1'b1;
                  rd_addr  = lb_ff[AW-1:0];
                  state_in = ST_EQ;
               end
            end
         end
         ST_EQ: begin
            // entry at the lower bound is in rd_data_ff; wait for a free output slot
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = hit ? diff32[COUNT_W-1:0] : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         pend_ff        <= 1'b0;
         phase_ff       <= 1'b0;
         entry_count_ff <= COUNT_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         phase_ff     <= phase_in;
         if (csr_wr_en) begin
            entry_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      lb_ff        <= lb_in;
      ub_ff        <= ub_in;
      n_ff         <= n_in;
      key_ff       <= key_in;
   end

endmodule

// ===== hdl/stkc_checker.sv =====
// Port-level checks for the sorted table key counter, bound to the top level
`include "assert_macros.svh"

module stkc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] rsp_count
);

   logic req_xfer;
   logic rsp_stall;

   assign req_xfer  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // a pending response stays up with the same count
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_count))
   // a write transfer never blocks the next request
   `ASSERT_NEXT(a_write_ready, clock, reset, req_xfer && !req_kind, req_ready)
   // a query transfer occupies the block for at least the next cycle
   `ASSERT_NEXT(a_query_busy, clock, reset, req_xfer && req_kind, !req_ready)
   // nothing comes out in the cycle after reset
   `ASSERT_NOW(a_reset_quiet, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind sorted_table_key_count_top stkc_checker u_stkc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_kind  (req_if.data.req_type),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_count (rsp_if.data.match_count)
);
